>>> rtl/bms_pkg.sv
`timescale 1ns / 1ps
// Constants, note and colour tables, and lookup functions for the button
// melody sequencer. Depends on nothing; every other file imports it.
package bms_pkg;

   localparam int KEY_COUNT        = 3;
   localparam int SONG_COUNT       = 3;
   localparam int NOTES_PER_SONG   = 16;
   localparam int TICKS_PER_SECOND = 1000;
   localparam int COLOUR_COUNT     = 8;

   localparam int TONE_W  = 10;
   localparam int LED_W   = 8;
   localparam int SONG_W  = 2;
   localparam int NOTE_W  = 5;
   localparam int PHASE_W = 10;
   localparam int DEB_W   = 8;
   localparam int GAP_W   = 7;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd50;
   localparam logic [GAP_W-1:0] GAP_RESET      = 7'd30;

   // Register word index, taken from paddr bit 2.
   localparam logic REG_DEBOUNCE = 1'b0;
   localparam logic REG_GAP      = 1'b1;

   localparam logic [PHASE_W-1:0] PHASE_MAX = '1;

   // Note length classes: eighth, quarter and half of a second.
   typedef logic [1:0] len_class_type;
   localparam len_class_type LEN_E = 2'd0;
   localparam len_class_type LEN_Q = 2'd1;
   localparam len_class_type LEN_H = 2'd2;

   localparam logic [PHASE_W-1:0] TICKS_E = PHASE_W'(TICKS_PER_SECOND / 8);
   localparam logic [PHASE_W-1:0] TICKS_Q = PHASE_W'(TICKS_PER_SECOND / 4);
   localparam logic [PHASE_W-1:0] TICKS_H = PHASE_W'(TICKS_PER_SECOND / 2);

   localparam logic [TONE_W-1:0] PITCH_ROM [SONG_COUNT][NOTES_PER_SONG] = '{
      '{10'd523, 10'd523, 10'd440, 10'd523, 10'd0,   10'd392, 10'd0,   10'd392,
        10'd523, 10'd349, 10'd330, 10'd523, 10'd0,   10'd0,   10'd0,   10'd0},
      '{10'd330, 10'd392, 10'd440, 10'd0,   10'd330, 10'd392, 10'd494, 10'd440,
        10'd330, 10'd392, 10'd440, 10'd0,   10'd392, 10'd330, 10'd0,   10'd0},
      '{10'd262, 10'd294, 10'd330, 10'd349, 10'd0,   10'd0,   10'd294, 10'd330,
        10'd349, 10'd392, 10'd0,   10'd0,   10'd294, 10'd330, 10'd349, 10'd392}
   };

   localparam len_class_type LEN_ROM [SONG_COUNT][NOTES_PER_SONG] = '{
      '{LEN_E, LEN_E, LEN_E, LEN_E, LEN_E, LEN_Q, LEN_E, LEN_Q,
        LEN_Q, LEN_Q, LEN_Q, LEN_H, LEN_Q, LEN_Q, LEN_Q, LEN_Q},
      '{LEN_Q, LEN_Q, LEN_Q, LEN_E, LEN_Q, LEN_Q, LEN_E, LEN_H,
        LEN_Q, LEN_Q, LEN_Q, LEN_E, LEN_Q, LEN_H, LEN_Q, LEN_Q},
      '{LEN_E, LEN_E, LEN_E, LEN_E, LEN_Q, LEN_Q, LEN_E, LEN_E,
        LEN_E, LEN_E, LEN_Q, LEN_Q, LEN_E, LEN_E, LEN_E, LEN_E}
   };

   typedef struct packed {
      logic [LED_W-1:0] red;
      logic [LED_W-1:0] green;
      logic [LED_W-1:0] blue;
   } colour_type;

   localparam colour_type COLOUR_ROM [COLOUR_COUNT] = '{
      '{8'd255, 8'd0,   8'd0},   '{8'd0,   8'd255, 8'd0},
      '{8'd0,   8'd0,   8'd255}, '{8'd255, 8'd255, 8'd0},
      '{8'd255, 8'd0,   8'd255}, '{8'd0,   8'd255, 8'd255},
      '{8'd255, 8'd100, 8'd0},   '{8'd255, 8'd255, 8'd255}
   };

   // Positions past the stored notes and songs read as a quarter rest.
   function automatic logic [TONE_W-1:0] pitch_of(input logic [SONG_W-1:0] song,
                                                  input logic [NOTE_W-1:0] pos);
      logic [TONE_W-1:0] hz;
      hz = '0;
      if (int'(song) < SONG_COUNT && int'(pos) < NOTES_PER_SONG) begin
         hz = PITCH_ROM[song][pos[3:0]];
      end
      return hz;
   endfunction

   function automatic len_class_type class_of(input logic [SONG_W-1:0] song,
                                              input logic [NOTE_W-1:0] pos);
      len_class_type lc;
      lc = LEN_Q;
      if (int'(song) < SONG_COUNT && int'(pos) < NOTES_PER_SONG) begin
         lc = LEN_ROM[song][pos[3:0]];
      end
      return lc;
   endfunction

endpackage

>>> rtl/bms_req_if.sv
`timescale 1ns / 1ps
// Input channel of the melody sequencer: one beat per tick, three raw
// active-low button levels. Uses bms_pkg.
interface bms_req_if import bms_pkg::*; ();
   logic valid;
   logic ready;
   logic button_one_level;
   logic button_two_level;
   logic button_three_level;

   modport source (output valid, output button_one_level, output button_two_level,
                   output button_three_level, input ready);
   modport sink (input valid, input button_one_level, input button_two_level,
                 input button_three_level, output ready);
endinterface

>>> rtl/bms_rsp_if.sv
`timescale 1ns / 1ps
// Result channel of the melody sequencer: tone, LED colour and playback
// status for each tick. Uses bms_pkg for field widths.
interface bms_rsp_if import bms_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TONE_W-1:0] tone_hz;
   logic [LED_W-1:0]  led_red;
   logic [LED_W-1:0]  led_green;
   logic [LED_W-1:0]  led_blue;
   logic              is_playing;
   logic [SONG_W-1:0] song_number;
   logic [NOTE_W-1:0] note_number;
   logic              in_gap;
   logic              song_done;

   modport source (output valid, output tone_hz, output led_red, output led_green,
                   output led_blue, output is_playing, output song_number,
                   output note_number, output in_gap, output song_done, input ready);
   modport sink (input valid, input tone_hz, input led_red, input led_green,
                 input led_blue, input is_playing, input song_number,
                 input note_number, input in_gap, input song_done, output ready);
endinterface

>>> rtl/button_melody_sequencer_unit.sv
`timescale 1ns / 1ps
// Button melody sequencer top level: debouncing, playback state and result
// register. Depends on bms_pkg, bms_req_if and bms_rsp_if.
// The result beat for a tick is registered and valid in the cycle after the tick is taken.
// Throughput: one tick per cycle; a new tick is taken whenever the result
// register is empty or is being drained in the same cycle.
// Reset (synchronous, active high) releases all buttons, stops playback,
// restores the default debounce and gap settings and empties the result register.
module button_melody_sequencer_unit import bms_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   bms_req_if.sink           req_chan,
   bms_rsp_if.source         rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   logic [DEB_W-1:0]   debounce_ff;
   logic [GAP_W-1:0]   gap_pct_ff;
   logic [DEB_W-1:0]   stable_ff [KEY_COUNT];
   logic [DEB_W-1:0]   stable_in [KEY_COUNT];
   logic [KEY_COUNT-1:0] accepted_ff, accepted_in;
   logic [KEY_COUNT-1:0] prev_raw_ff;
   logic [SONG_W-1:0]  melody_ff, melody_in;
   logic [NOTE_W-1:0]  pos_ff, pos_in;
   logic               playing_ff, playing_in;
   logic               note_ff, note_in;
   logic               gap_ff, gap_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               done_in;

   logic               rsp_valid_ff;
   logic [TONE_W-1:0]  tone_ff, tone_in;
   colour_type         colour_ff, colour_in;
   logic [SONG_W-1:0]  song_out_in;
   logic               playing_out_ff;
   logic [SONG_W-1:0]  song_out_ff;
   logic [NOTE_W-1:0]  note_out_ff;
   logic               gap_out_ff;
   logic               done_ff;

   logic [KEY_COUNT-1:0] raw;
   logic               take;
   logic               csr_write;
   len_class_type      len_class;
   logic [PHASE_W-1:0] note_len;
   logic [PHASE_W-1:0] gap_len;
   logic [PHASE_W-1:0] gap_x5;

   assign raw = {req_chan.button_three_level, req_chan.button_two_level,
                 req_chan.button_one_level};
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign take = req_chan.valid && req_chan.ready;

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_GAP) ? CSR_DW'(gap_pct_ff)
                                                 : CSR_DW'(debounce_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         gap_pct_ff  <= GAP_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_DEBOUNCE: debounce_ff <= csr_pwdata[DEB_W-1:0];
            REG_GAP:      gap_pct_ff  <= csr_pwdata[GAP_W-1:0];
            default:      ;
         endcase
      end
   end

   // Gap length is note length * percent / 100. With notes of 1/8, 1/4 and 1/2
   // second this is 5 * percent shifted right by 2, 1 or 0, exactly.
   assign gap_x5 = PHASE_W'({gap_pct_ff, 2'b00}) + PHASE_W'(gap_pct_ff);

   always_comb begin
      stable_in   = stable_ff;
      accepted_in = accepted_ff;
      melody_in   = melody_ff;
      pos_in      = pos_ff;
      playing_in  = playing_ff;
      note_in     = note_ff;
      gap_in      = gap_ff;
      phase_in    = phase_ff;
      done_in     = 1'b0;
      len_class   = LEN_Q;
      note_len    = TICKS_Q;
      gap_len     = '0;

      if (playing_ff && phase_ff != PHASE_MAX) begin
         phase_in = phase_ff + 1'b1;
      end

      // Debounce each button; when several presses land on one tick the
      // highest-numbered button is the one that sticks.
      for (int k = 0; k < KEY_COUNT; k++) begin
         if (raw[k] != prev_raw_ff[k]) begin
            stable_in[k] = '0;
         end else if (stable_ff[k] != '1) begin
            stable_in[k] = stable_ff[k] + 1'b1;
         end
         if (stable_in[k] >= debounce_ff && raw[k] != accepted_ff[k]) begin
            accepted_in[k] = raw[k];
            if (!raw[k] && k < SONG_COUNT) begin
               melody_in  = SONG_W'(k);
               pos_in     = '0;
               playing_in = 1'b1;
               phase_in   = '0;
               note_in    = 1'b1;
               gap_in     = 1'b0;
            end
         end
      end

      if (playing_in) begin
         len_class = class_of(melody_in, pos_in);
         case (len_class)
            LEN_E: begin
               note_len = TICKS_E;
               gap_len  = gap_x5 >> 2;
            end
            LEN_H: begin
               note_len = TICKS_H;
               gap_len  = gap_x5;
            end
            default: begin
               note_len = TICKS_Q;
               gap_len  = gap_x5 >> 1;
            end
         endcase
         if (note_in && phase_in >= note_len) begin
            note_in  = 1'b0;
            gap_in   = 1'b1;
            phase_in = '0;
         end
         // A zero-length gap closes on the tick it opens.
         if (gap_in && phase_in >= gap_len) begin
            gap_in = 1'b0;
            pos_in = pos_in + 1'b1;
            if (int'(pos_in) >= NOTES_PER_SONG) begin
               playing_in = 1'b0;
               note_in    = 1'b0;
               done_in    = 1'b1;
            end else begin
               phase_in = '0;
               note_in  = 1'b1;
            end
         end
      end

      tone_in   = '0;
      colour_in = '0;
      if (playing_in && note_in) begin
         tone_in = pitch_of(melody_in, pos_in);
         if (tone_in != '0) begin
            colour_in = COLOUR_ROM[pos_in[$clog2(COLOUR_COUNT)-1:0]];
         end
      end
      song_out_in = playing_in ? melody_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEY_COUNT; k++) begin
            stable_ff[k] <= '0;
         end
         accepted_ff  <= '1;
         prev_raw_ff  <= '1;
         melody_ff    <= '0;
         pos_ff       <= '0;
         playing_ff   <= 1'b0;
         note_ff      <= 1'b0;
         gap_ff       <= 1'b0;
         phase_ff     <= '0;
      end else if (take) begin
         stable_ff    <= stable_in;
         accepted_ff  <= accepted_in;
         prev_raw_ff  <= raw;
         melody_ff    <= melody_in;
         pos_ff       <= pos_in;
         playing_ff   <= playing_in;
         note_ff      <= note_in;
         gap_ff       <= gap_in;
         phase_ff     <= phase_in;
      end
   end

   // Result register; payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         tone_ff        <= tone_in;
         colour_ff      <= colour_in;
         playing_out_ff <= playing_in;
         song_out_ff    <= song_out_in;
         note_out_ff    <= pos_in;
         gap_out_ff     <= gap_in;
         done_ff        <= done_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.tone_hz     = tone_ff;
   assign rsp_chan.led_red     = colour_ff.red;
   assign rsp_chan.led_green   = colour_ff.green;
   assign rsp_chan.led_blue    = colour_ff.blue;
   assign rsp_chan.is_playing  = playing_out_ff;
   assign rsp_chan.song_number = song_out_ff;
   assign rsp_chan.note_number = note_out_ff;
   assign rsp_chan.in_gap      = gap_out_ff;
   assign rsp_chan.song_done   = done_ff;

`ifndef NO_ASSERTIONS
   // A note and its gap never overlap.
   assert property (@(posedge clock) disable iff (reset) !(note_ff && gap_ff))
      else $error("note and gap phases both active");

   // Nothing is sounding or gapping once playback has stopped.
   assert property (@(posedge clock) disable iff (reset)
                    !playing_ff |-> (!note_ff && !gap_ff))
      else $error("phase flag set while not playing");

   // The end-of-song beat reports playback as stopped, with the note number one past the last note.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && rsp_chan.song_done) |->
                    (!rsp_chan.is_playing && int'(rsp_chan.note_number) == NOTES_PER_SONG))
      else $error("song done beat with inconsistent status");

   // A sounding tone only appears while playing and outside a gap.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && tone_ff != '0) |->
                    (rsp_chan.is_playing && !rsp_chan.in_gap))
      else $error("tone output while silent");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for button_melody_sequencer_unit: a directed tick table,
// then random button episodes under several register settings, every result beat
// checked against its table entry or a local model. Depends on bms_pkg, bms_req_if and bms_rsp_if.
module testbench;
   import bms_pkg::*;

   typedef struct packed {
      logic [TONE_W-1:0] tone_hz;
      logic [LED_W-1:0]  led_red;
      logic [LED_W-1:0]  led_green;
      logic [LED_W-1:0]  led_blue;
      logic              is_playing;
      logic [SONG_W-1:0] song_number;
      logic [NOTE_W-1:0] note_number;
      logic              in_gap;
      logic              song_done;
   } tick_result_type;

   typedef enum logic {ROW_TICK, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [2:0]        levels;   // {three, two, one}, 1 means released
      logic              reg_sel;
      logic [CSR_DW-1:0] value;
      logic              typed;
      tick_result_type   want;
   } stim_row_type;

   localparam tick_result_type SILENT = '0;
   localparam tick_result_type START_ONE =
      '{10'd523, 8'd255, 8'd0, 8'd0, 1'b1, 2'd0, 5'd0, 1'b0, 1'b0};
   localparam tick_result_type START_TWO =
      '{10'd330, 8'd255, 8'd0, 8'd0, 1'b1, 2'd1, 5'd0, 1'b0, 1'b0};
   localparam tick_result_type START_THREE =
      '{10'd262, 8'd255, 8'd0, 8'd0, 1'b1, 2'd2, 5'd0, 1'b0, 1'b0};

   localparam int DIRECTED_ROWS = 23;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{ROW_TICK, 3'b111, REG_DEBOUNCE, 32'd0,   1'b1, SILENT},
      '{ROW_TICK, 3'b111, REG_DEBOUNCE, 32'd0,   1'b1, SILENT},
      '{ROW_TICK, 3'b111, REG_DEBOUNCE, 32'd0,   1'b1, SILENT},
      '{ROW_TICK, 3'b000, REG_DEBOUNCE, 32'd0,   1'b1, SILENT},
      '{ROW_TICK, 3'b111, REG_DEBOUNCE, 32'd0,   1'b1, SILENT},
      '{ROW_CFG,  3'b111, REG_DEBOUNCE, 32'd0,   1'b0, SILENT},
      '{ROW_CFG,  3'b111, REG_GAP,      32'd0,   1'b0, SILENT},
      '{ROW_TICK, 3'b000, REG_DEBOUNCE, 32'd0,   1'b1, START_THREE},
      '{ROW_TICK, 3'b000, REG_DEBOUNCE, 32'd0,   1'b0, SILENT},
      '{ROW_TICK, 3'b111, REG_DEBOUNCE, 32'd0,   1'b0, SILENT},
      '{ROW_TICK, 3'b110, REG_DEBOUNCE, 32'd0,   1'b1, START_ONE},
      '{ROW_TICK, 3'b101, REG_DEBOUNCE, 32'd0,   1'b1, START_TWO},
      '{ROW_TICK, 3'b011, REG_DEBOUNCE, 32'd0,   1'b1, START_THREE},
      '{ROW_CFG,  3'b111, REG_DEBOUNCE, 32'd255, 1'b0, SILENT},
      '{ROW_CFG,  3'b111, REG_GAP,      32'd127, 1'b0, SILENT},
      '{ROW_TICK, 3'b111, REG_DEBOUNCE, 32'd0,   1'b0, SILENT},
      '{ROW_TICK, 3'b000, REG_DEBOUNCE, 32'd0,   1'b0, SILENT},
      '{ROW_TICK, 3'b010, REG_DEBOUNCE, 32'd0,   1'b0, SILENT},
      '{ROW_CFG,  3'b111, REG_DEBOUNCE, 32'd1,   1'b0, SILENT},
      '{ROW_CFG,  3'b111, REG_GAP,      32'd100, 1'b0, SILENT},
      '{ROW_TICK, 3'b110, REG_DEBOUNCE, 32'd0,   1'b0, SILENT},
      '{ROW_TICK, 3'b110, REG_DEBOUNCE, 32'd0,   1'b0, SILENT},
      '{ROW_TICK, 3'b111, REG_DEBOUNCE, 32'd0,   1'b0, SILENT}
   };

   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_DEBOUNCE [RANDOM_PHASES] = '{0, 255, 3, 1, 12, 0, 5};
   localparam int PHASE_GAP      [RANDOM_PHASES] = '{0, 127, 100, 30, 64, 127, 1};
   localparam int PHASE_BUDGET   [RANDOM_PHASES] = '{60, 1, 60, 60, 60, 60, 60};
   localparam int TARGET_TICKS = 1450;

   localparam int TONE_TABLE [SONG_COUNT][NOTES_PER_SONG] = '{
      '{523, 523, 440, 523, 0, 392, 0, 392, 523, 349, 330, 523, 0, 0, 0, 0},
      '{330, 392, 440, 0, 330, 392, 494, 440, 330, 392, 440, 0, 392, 330, 0, 0},
      '{262, 294, 330, 349, 0, 0, 294, 330, 349, 392, 0, 0, 294, 330, 349, 392}
   };

   localparam int NOTE_TICKS [SONG_COUNT][NOTES_PER_SONG] = '{
      '{125, 125, 125, 125, 125, 250, 125, 250, 250, 250, 250, 500, 250, 250, 250, 250},
      '{250, 250, 250, 125, 250, 250, 125, 500, 250, 250, 250, 125, 250, 500, 250, 250},
      '{125, 125, 125, 125, 250, 250, 125, 125, 125, 125, 250, 250, 125, 125, 125, 125}
   };

   localparam logic [23:0] SHADES [COLOUR_COUNT] = '{
      24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
      24'hFF00FF, 24'h00FFFF, 24'hFF6400, 24'hFFFFFF
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   bms_req_if req_bus ();
   bms_rsp_if rsp_bus ();

   button_melody_sequencer_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Local copy of the sequencer state and its registers.
   logic [DEB_W-1:0]   stable_cnt [KEY_COUNT];
   logic               held_level [KEY_COUNT];
   logic               last_raw   [KEY_COUNT];
   logic [SONG_W-1:0]  song_sel;
   logic [NOTE_W-1:0]  note_pos;
   logic               playing;
   logic               sounding;
   logic               resting;
   logic [PHASE_W-1:0] phase_cnt;
   logic [DEB_W-1:0]   debounce_cfg;
   logic [GAP_W-1:0]   gap_cfg;

   tick_result_type expected_beats [$];
   int errors = 0;
   int results_checked = 0;
   int ticks_sent = 0;
   int melody_starts = 0;
   int notes_finished = 0;
   int songs_finished = 0;
   bit calm = 1'b0;
   bit send_idle_en = 1'b1;
   bit long_hold_done = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic start_note();
      if (note_pos >= NOTES_PER_SONG) begin
         playing  = 1'b0;
         sounding = 1'b0;
         resting  = 1'b0;
         songs_finished++;
         return 1'b1;
      end
      phase_cnt = '0;
      sounding  = 1'b1;
      resting   = 1'b0;
      return 1'b0;
   endfunction

   function automatic tick_result_type advance_tick(input logic [2:0] levels);
      tick_result_type res;
      logic finished;
      int len;
      logic [23:0] shade;
      res = SILENT;
      finished = 1'b0;
      if (playing && phase_cnt != PHASE_MAX) phase_cnt = phase_cnt + 1'b1;
      for (int k = 0; k < KEY_COUNT; k++) begin
         if (levels[k] != last_raw[k]) begin
            stable_cnt[k] = '0;
         end else if (stable_cnt[k] != 8'hFF) begin
            stable_cnt[k] = stable_cnt[k] + 1'b1;
         end
         if (stable_cnt[k] >= debounce_cfg && levels[k] != held_level[k]) begin
            held_level[k] = levels[k];
            // A fresh press restarts its melody; later buttons override earlier ones.
            if (!levels[k] && k < SONG_COUNT) begin
               song_sel = SONG_W'(k);
               note_pos = '0;
               playing  = 1'b1;
               melody_starts++;
               finished = finished | start_note();
            end
         end
         last_raw[k] = levels[k];
      end
      if (playing) begin
         len = TICKS_PER_SECOND / 4;
         if (int'(song_sel) < SONG_COUNT && int'(note_pos) < NOTES_PER_SONG)
            len = NOTE_TICKS[song_sel][note_pos[3:0]];
         if (sounding && int'(phase_cnt) >= len) begin
            sounding  = 1'b0;
            resting   = 1'b1;
            phase_cnt = '0;
            notes_finished++;
         end
         // A zero-length gap closes on the tick it opens.
         if (resting && int'(phase_cnt) >= len * int'(gap_cfg) / 100) begin
            resting  = 1'b0;
            note_pos = note_pos + 1'b1;
            finished = finished | start_note();
         end
      end
      if (playing && sounding) begin
         if (int'(song_sel) < SONG_COUNT && int'(note_pos) < NOTES_PER_SONG)
            res.tone_hz = TONE_W'(TONE_TABLE[song_sel][note_pos[3:0]]);
         if (res.tone_hz != '0) begin
            shade = SHADES[note_pos[2:0]];
            res.led_red   = shade[23:16];
            res.led_green = shade[15:8];
            res.led_blue  = shade[7:0];
         end
      end
      res.is_playing  = playing;
      res.song_number = playing ? song_sel : '0;
      res.note_number = note_pos;
      res.in_gap      = resting;
      res.song_done   = finished;
      return res;
   endfunction

   function automatic void check_field(input string label, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      end
   endfunction

   task automatic send_tick(input logic [2:0] levels, input logic typed,
                            input tick_result_type want);
      tick_result_type got;
      if (!calm && send_idle_en && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_bus.valid              <= 1'b1;
      req_bus.button_one_level   <= levels[0];
      req_bus.button_two_level   <= levels[1];
      req_bus.button_three_level <= levels[2];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      got = advance_tick(levels);
      expected_beats.push_back(typed ? want : got);
      ticks_sent++;
   endtask

   task automatic drain_results();
      int waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      while (expected_beats.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_read_check(input logic reg_sel, input logic [CSR_DW-1:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {reg_sel, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== want) begin
         errors++;
         $display("%0t ns: register %0d read mismatch, expected %0d, actual %0d",
                  $time, reg_sel, want, csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_sel, input logic [CSR_DW-1:0] value);
      drain_results();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (reg_sel == REG_DEBOUNCE) begin
         debounce_cfg = value[DEB_W-1:0];
      end else begin
         gap_cfg = value[GAP_W-1:0];
      end
      csr_read_check(reg_sel, (reg_sel == REG_DEBOUNCE) ? CSR_DW'(debounce_cfg)
                                                         : CSR_DW'(gap_cfg));
   endtask

   // Mostly clean presses with contact bounce and a hold past the debounce time,
   // sometimes released early, sometimes pure noise on all three lines.
   task automatic play_episode();
      logic [2:0] mask;
      int hold;
      int pick;
      pick = $urandom_range(0, 9);
      send_idle_en = ($urandom_range(0, 3) != 0);
      if (pick >= 8) begin
         repeat ($urandom_range(1, 12)) send_tick(3'($urandom), 1'b0, SILENT);
      end else begin
         mask = 3'b001 << $urandom_range(0, 2);
         if ($urandom_range(0, 4) == 0) mask = 3'($urandom_range(1, 7));
         repeat ($urandom_range(0, 5)) send_tick(~(mask & 3'($urandom)), 1'b0, SILENT);
         hold = int'(debounce_cfg) + $urandom_range(1, 20);
         if (pick == 7) hold = $urandom_range(1, int'(debounce_cfg) + 1);
         repeat (hold) send_tick(~mask, 1'b0, SILENT);
         repeat ($urandom_range(0, 5)) send_tick(~(mask & 3'($urandom)), 1'b0, SILENT);
         hold = int'(debounce_cfg) + (($urandom_range(0, 2) == 0) ? $urandom_range(100, 420)
                                                                 : $urandom_range(1, 30));
         repeat (hold) send_tick(3'b111, 1'b0, SILENT);
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      tick_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_beats.size() == 0) begin
            errors++;
            $display("%0t ns: result beat arrived with nothing expected", $time);
         end else begin
            want = expected_beats.pop_front();
            check_field("tone_hz",     32'(want.tone_hz),     32'(rsp_bus.tone_hz));
            check_field("led_red",     32'(want.led_red),     32'(rsp_bus.led_red));
            check_field("led_green",   32'(want.led_green),   32'(rsp_bus.led_green));
            check_field("led_blue",    32'(want.led_blue),    32'(rsp_bus.led_blue));
            check_field("is_playing",  32'(want.is_playing),  32'(rsp_bus.is_playing));
            check_field("song_number", 32'(want.song_number), 32'(rsp_bus.song_number));
            check_field("note_number", 32'(want.note_number), 32'(rsp_bus.note_number));
            check_field("in_gap",      32'(want.in_gap),      32'(rsp_bus.in_gap));
            check_field("song_done",   32'(want.song_done),   32'(rsp_bus.song_done));
            results_checked++;
         end
      end
   end

   initial begin : rsp_pacing
      bit idle_en;
      idle_en = 1'b1;
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (!long_hold_done && results_checked >= 400) begin
            // Long back-pressure so the result register fills and the input stalls.
            rsp_bus.ready <= 1'b0;
            repeat (300) @(posedge clock);
            long_hold_done = 1'b1;
            rsp_bus.ready <= 1'b1;
         end else if (!calm && idle_en && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
         if ($urandom_range(0, 63) == 0) idle_en = !idle_en;
      end
   end

   initial begin : stimulus
      int start_tick;
      reset                      = 1'b1;
      csr_psel                   = 1'b0;
      csr_penable                = 1'b0;
      csr_pwrite                 = 1'b0;
      csr_paddr                  = '0;
      csr_pwdata                 = '0;
      req_bus.valid              = 1'b0;
      req_bus.button_one_level   = 1'b1;
      req_bus.button_two_level   = 1'b1;
      req_bus.button_three_level = 1'b1;
      for (int k = 0; k < KEY_COUNT; k++) begin
         stable_cnt[k] = '0;
         held_level[k] = 1'b1;
         last_raw[k]   = 1'b1;
      end
      song_sel     = '0;
      note_pos     = '0;
      playing      = 1'b0;
      sounding     = 1'b0;
      resting      = 1'b0;
      phase_cnt    = '0;
      debounce_cfg = 8'd50;
      gap_cfg      = 7'd30;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      csr_read_check(REG_DEBOUNCE, 32'd50);
      csr_read_check(REG_GAP, 32'd30);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (DIRECTED[i].kind == ROW_CFG) begin
            csr_write(DIRECTED[i].reg_sel, DIRECTED[i].value);
         end else begin
            send_tick(DIRECTED[i].levels, DIRECTED[i].typed, DIRECTED[i].want);
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         csr_write(REG_DEBOUNCE, CSR_DW'(PHASE_DEBOUNCE[p]));
         csr_write(REG_GAP, CSR_DW'(PHASE_GAP[p]));
         start_tick = ticks_sent;
         while (ticks_sent - start_tick < PHASE_BUDGET[p]) play_episode();
      end

      // Close with a melody started and played on with no idling on either side.
      csr_write(REG_DEBOUNCE, CSR_DW'(2));
      csr_write(REG_GAP, CSR_DW'(10));
      calm = 1'b1;
      repeat (8) send_tick(3'b111, 1'b0, SILENT);
      repeat (4) send_tick(3'b011, 1'b0, SILENT);
      repeat (20) send_tick(3'b111, 1'b0, SILENT);
      while (ticks_sent < TARGET_TICKS) send_tick(3'b111, 1'b0, SILENT);

      drain_results();
      if (expected_beats.size() != 0) begin
         errors += expected_beats.size();
         $display("%0t ns: %0d expected result beats never arrived",
                  $time, expected_beats.size());
      end
      $display("Run covered %0d ticks and %0d checked result beats over %0d register settings.",
               ticks_sent, results_checked, RANDOM_PHASES + 4);
      $display("Melodies started %0d times, %0d notes ran out, %0d songs played to the end.",
               melody_starts, notes_finished, songs_finished);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : watchdog
      #4_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
